// ----- hdl/perspective_point_projection_unit_assert.svh -----
// Assertion macros shared by the projection unit.
// Used only by the top level of the projection unit.
`ifndef PERSPECTIVE_POINT_PROJECTION_UNIT_ASSERT_SVH
`define PERSPECTIVE_POINT_PROJECTION_UNIT_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define PPU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("projection unit check failed");

// Next-cycle implication checked through reset as well.
`define PPU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("projection unit check failed");

`endif

// ----- hdl/ppu_pkg.sv -----
// Shared types, widths and constants of the perspective projection unit.
// No dependencies.
package ppu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VEC_BITS  = 21;
  localparam int VEC_FRAC  = 19;
  localparam int TAN_Q24   = 6949350;
  localparam int NEAR_Q    = ((1 << FRAC_BITS) + 5) / 10;

  // Camera-space coordinate, product and sum widths.
  localparam int REL_W  = 33;
  localparam int PROD_W = REL_W + VEC_BITS;
  localparam int ACC_W  = PROD_W + 2;
  localparam int XYZ_W  = ACC_W - VEC_FRAC;
  localparam int ZP_W   = XYZ_W + 24;
  localparam int ZT_W   = XYZ_W - 1;
  localparam int NUM_W  = XYZ_W + 16;
  localparam int LIM_W  = ZT_W + 16;
  localparam int DEN_W  = ZT_W + 1;
  localparam int QUO_W  = FRAC_BITS + 18;
  localparam int DIV_LAT = QUO_W;

  // Configuration register indexes.
  localparam logic [2:0] REG_EYE_X   = 3'd0;
  localparam logic [2:0] REG_EYE_Y   = 3'd1;
  localparam logic [2:0] REG_EYE_Z   = 3'd2;
  localparam logic [2:0] REG_RIGHT   = 3'd3;
  localparam logic [2:0] REG_UP      = 3'd4;
  localparam logic [2:0] REG_FORWARD = 3'd5;
  localparam logic [2:0] REG_CMIN    = 3'd6;
  localparam logic [2:0] REG_CMAX    = 3'd7;

  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][62:0] vec;
    logic [31:0]      canvas_min;
    logic [31:0]      canvas_max;
  } cfg_t;

  typedef struct packed {
    logic                    valid;
    logic signed [XYZ_W-1:0] x;
    logic signed [XYZ_W-1:0] y;
    logic signed [XYZ_W-1:0] z;
  } xyz_t;

  typedef struct packed {
    logic             valid;
    logic             vis;
    logic             neg_x;
    logic             neg_y;
    logic [NUM_W-1:0] nx;
    logic [NUM_W-1:0] ny;
    logic [DEN_W-1:0] den;
  } clip_t;

  typedef struct packed {
    logic valid;
    logic vis;
    logic neg_x;
    logic neg_y;
  } tag_t;

endpackage

// ----- hdl/ppu_xform.sv -----
// Camera transform: eye subtraction, nine products and per-axis sums.
// Depends on ppu_pkg.
module ppu_xform (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2:0][31:0]    point,
  input  ppu_pkg::cfg_t       cfg,
  output ppu_pkg::xyz_t       out
);

  logic                                  v1, v2;
  logic signed [2:0][ppu_pkg::REL_W-1:0] rel;
  logic signed [ppu_pkg::PROD_W-1:0]     prod [3][3];
  logic signed [ppu_pkg::ACC_W-1:0]      acc  [3];

  // Stage 1: point relative to the eye.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rel[k] <= $signed({point[k][31], point[k]}) - $signed({cfg.eye[k][31], cfg.eye[k]});
      end
    end
  end

  // Stage 2: one product per axis and component.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 3; k++) begin
          prod[a][k] <= $signed(rel[k])
                      * $signed(cfg.vec[a][ppu_pkg::VEC_BITS*k +: ppu_pkg::VEC_BITS]);
        end
      end
    end
  end

  // Stage 3: exact sums, then floor shift to the point's fraction.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      acc[a] = ppu_pkg::ACC_W'(prod[a][0]) + ppu_pkg::ACC_W'(prod[a][1])
             + ppu_pkg::ACC_W'(prod[a][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (en) begin
      out.valid <= v2;
    end
    if (en) begin
      out.x <= acc[0][ppu_pkg::ACC_W-1:ppu_pkg::VEC_FRAC];
      out.y <= acc[1][ppu_pkg::ACC_W-1:ppu_pkg::VEC_FRAC];
      out.z <= acc[2][ppu_pkg::ACC_W-1:ppu_pkg::VEC_FRAC];
    end
  end

endmodule

// ----- hdl/ppu_clip.sv -----
// Depth test, tangent scaling and guard-band test ahead of the dividers.
// Depends on ppu_pkg.
module ppu_clip (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  ppu_pkg::xyz_t  in,
  input  ppu_pkg::cfg_t  cfg,
  output ppu_pkg::clip_t out
);

  logic signed [16:0] wd, hd;
  logic [15:0]        w, h;

  logic                           v4, near4, nx4_neg, ny4_neg;
  logic signed [ppu_pkg::ZP_W-1:0] zprod;
  logic [ppu_pkg::XYZ_W-1:0]      ax4, ay4;

  logic                            v5, near5, neg_x5, neg_y5;
  logic signed [ppu_pkg::XYZ_W-1:0] zs;
  logic [ppu_pkg::ZT_W-1:0]        zt5;
  logic [ppu_pkg::NUM_W-1:0]       nx5, ny5;
  logic [ppu_pkg::XYZ_W-1:0]       ay5;

  logic                            v6, near6, neg_x6, neg_y6;
  logic [ppu_pkg::ZT_W-1:0]        zt6;
  logic [ppu_pkg::LIM_W-1:0]       lim6;
  logic [ppu_pkg::NUM_W-1:0]       nx6, ny6;
  logic [ppu_pkg::XYZ_W-1:0]       ay6;
  logic                            rej;

  // Canvas size, empty or inverted spans taken as one pixel.
  always_comb begin
    wd = $signed({1'b0, cfg.canvas_max[15:0]}) - $signed({1'b0, cfg.canvas_min[15:0]});
    hd = $signed({1'b0, cfg.canvas_max[31:16]}) - $signed({1'b0, cfg.canvas_min[31:16]});
    w  = (wd < 17'sd1) ? 16'd1 : wd[15:0];
    h  = (hd < 17'sd1) ? 16'd1 : hd[15:0];
  end

  // Stage 4: depth test, depth times tangent, magnitudes.
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= in.valid;
    end
    if (en) begin
      near4   <= in.z <= ppu_pkg::XYZ_W'(ppu_pkg::NEAR_Q);
      zprod   <= in.z * $signed({1'b0, 23'(ppu_pkg::TAN_Q24)});
      nx4_neg <= in.x[ppu_pkg::XYZ_W-1];
      ny4_neg <= in.y[ppu_pkg::XYZ_W-1];
      ax4     <= in.x[ppu_pkg::XYZ_W-1] ? ppu_pkg::XYZ_W'(-in.x) : ppu_pkg::XYZ_W'(in.x);
      ay4     <= in.y[ppu_pkg::XYZ_W-1] ? ppu_pkg::XYZ_W'(-in.y) : ppu_pkg::XYZ_W'(in.y);
    end
  end

  // Stage 5: scaled depth with floor of one, numerators scaled by height.
  assign zs = zprod[ppu_pkg::ZP_W-1:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      near5  <= near4;
      neg_x5 <= nx4_neg;
      neg_y5 <= ny4_neg;
      zt5    <= (zs < ppu_pkg::XYZ_W'(1)) ? ppu_pkg::ZT_W'(1) : zs[ppu_pkg::ZT_W-1:0];
      nx5    <= ppu_pkg::NUM_W'(ax4 * h);
      ny5    <= ppu_pkg::NUM_W'(ay4 * h);
      ay5    <= ay4;
    end
  end

  // Stage 6: guard-band limit for x.
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
    if (en) begin
      near6  <= near5;
      neg_x6 <= neg_x5;
      neg_y6 <= neg_y5;
      zt6    <= zt5;
      lim6   <= ppu_pkg::LIM_W'(zt5 * w);
      nx6    <= nx5;
      ny6    <= ny5;
      ay6    <= ay5;
    end
  end

  // Stage 7: guard-band compares, divisor is twice the scaled depth.
  assign rej = ({1'b0, nx6} > {lim6, 2'b00}) || ({2'b00, ay6} > {1'b0, zt6, 2'b00});

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (en) begin
      out.valid <= v6;
    end
    if (en) begin
      out.vis   <= !near6 && !rej;
      out.neg_x <= neg_x6;
      out.neg_y <= neg_y6;
      out.nx    <= nx6;
      out.ny    <= ny6;
      out.den   <= {zt6, 1'b0};
    end
  end

endmodule

// ----- hdl/ppu_div.sv -----
// Pipelined restoring divider, one quotient bit per stage: floor(num * 2^F / den).
// Depends on ppu_pkg; quotient must fit in QUO_W bits.
module ppu_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [ppu_pkg::NUM_W-1:0]  num,
  input  logic [ppu_pkg::DEN_W-1:0]  den,
  output logic [ppu_pkg::QUO_W-1:0]  quo
);

  localparam int QW = ppu_pkg::QUO_W;
  localparam int DW = ppu_pkg::DEN_W;
  localparam int SH = QW - ppu_pkg::FRAC_BITS;

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] bits_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [DW-1:0] den_q [QW];

  logic [DW-1:0] rem_d [QW];
  logic [QW-1:0] bits_d [QW];
  logic [QW-1:0] quo_d [QW];

  logic [DW-1:0] rem_s;
  logic [QW-1:0] bits_s, quo_s;
  logic [DW-1:0] den_s;
  logic [DW:0]   trial;

  // One compare and subtract per stage.
  always_comb begin
    for (int i = 0; i < QW; i++) begin
      if (i == 0) begin
        rem_s  = DW'(num >> SH);
        bits_s = {num[SH-1:0], {ppu_pkg::FRAC_BITS{1'b0}}};
        quo_s  = '0;
        den_s  = den;
      end else begin
        rem_s  = rem_q[i-1];
        bits_s = bits_q[i-1];
        quo_s  = quo_q[i-1];
        den_s  = den_q[i-1];
      end
      trial = {rem_s, bits_s[QW-1]};
      if (trial >= {1'b0, den_s}) begin
        rem_d[i] = DW'(trial - {1'b0, den_s});
        quo_d[i] = {quo_s[QW-2:0], 1'b1};
      end else begin
        rem_d[i] = trial[DW-1:0];
        quo_d[i] = {quo_s[QW-2:0], 1'b0};
      end
      bits_d[i] = {bits_s[QW-2:0], 1'b0};
    end
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QW; i++) begin
        rem_q[i]  <= rem_d[i];
        bits_q[i] <= bits_d[i];
        quo_q[i]  <= quo_d[i];
        den_q[i]  <= (i == 0) ? den : den_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

// ----- hdl/perspective_point_projection_unit.sv -----
// Perspective point projection: world point to canvas pixel, Q16.16.
// Pipeline of 7 transform/clip stages, 34 divider stages and 1 output stage;
// one point per cycle sustained while m_tready does not hold the output.
// The whole pipeline advances together and holds while a result waits.
// Synchronous active-high reset clears the configuration, the output and all valids.
// Depends on ppu_pkg, ppu_xform, ppu_clip, ppu_div and the assert header.
`include "perspective_point_projection_unit_assert.svh"

module perspective_point_projection_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // point_x[31:0], point_y[63:32], point_z[95:64]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // visible[0], screen_x[32:1], screen_y[64:33], zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [62:0] cfg_data
);

  localparam int F = ppu_pkg::FRAC_BITS;

  ppu_pkg::cfg_t  cfg;
  ppu_pkg::xyz_t  xyz;
  ppu_pkg::clip_t clip;
  ppu_pkg::tag_t  tag [ppu_pkg::DIV_LAT];
  logic           en;
  logic [ppu_pkg::QUO_W-1:0] qx, qy;
  logic [2:0][31:0] point;

  logic signed [39:0] ox, oy, sx, sy, basex, basey;
  logic signed [16:0] wd, hd;
  logic [15:0]        w, h;
  logic               out_vis;
  logic [31:0]        out_x, out_y;

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = !rst && en;
  assign cfg_ready = 1'b1;
  assign point     = s_tdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ppu_pkg::REG_EYE_X:   cfg.eye[0]     <= cfg_data[31:0];
        ppu_pkg::REG_EYE_Y:   cfg.eye[1]     <= cfg_data[31:0];
        ppu_pkg::REG_EYE_Z:   cfg.eye[2]     <= cfg_data[31:0];
        ppu_pkg::REG_RIGHT:   cfg.vec[0]     <= cfg_data;
        ppu_pkg::REG_UP:      cfg.vec[1]     <= cfg_data;
        ppu_pkg::REG_FORWARD: cfg.vec[2]     <= cfg_data;
        ppu_pkg::REG_CMIN:    cfg.canvas_min <= cfg_data[31:0];
        ppu_pkg::REG_CMAX:    cfg.canvas_max <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  ppu_xform u_xform (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid), .point(point), .cfg(cfg), .out(xyz)
  );

  ppu_clip u_clip (
    .clk(clk), .rst(rst), .en(en), .in(xyz), .cfg(cfg), .out(clip)
  );

  ppu_div u_div_x (.clk(clk), .en(en), .num(clip.nx), .den(clip.den), .quo(qx));
  ppu_div u_div_y (.clk(clk), .en(en), .num(clip.ny), .den(clip.den), .quo(qy));

  // Side band that travels beside the dividers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ppu_pkg::DIV_LAT; i++) begin
        tag[i] <= '0;
      end
    end else if (en) begin
      tag[0] <= '{valid: clip.valid, vis: clip.vis, neg_x: clip.neg_x, neg_y: clip.neg_y};
      for (int i = 1; i < ppu_pkg::DIV_LAT; i++) begin
        tag[i] <= tag[i-1];
      end
    end
  end

  // Canvas origin and center offset.
  always_comb begin
    wd    = $signed({1'b0, cfg.canvas_max[15:0]}) - $signed({1'b0, cfg.canvas_min[15:0]});
    hd    = $signed({1'b0, cfg.canvas_max[31:16]}) - $signed({1'b0, cfg.canvas_min[31:16]});
    w     = (wd < 17'sd1) ? 16'd1 : wd[15:0];
    h     = (hd < 17'sd1) ? 16'd1 : hd[15:0];
    basex = $signed(40'({cfg.canvas_min[15:0], {F{1'b0}}}) + 40'({w, {(F-1){1'b0}}}));
    basey = $signed(40'({cfg.canvas_min[31:16], {F{1'b0}}}) + 40'({h, {(F-1){1'b0}}}));
    ox    = tag[ppu_pkg::DIV_LAT-1].neg_x ? -$signed(40'(qx)) : $signed(40'(qx));
    oy    = tag[ppu_pkg::DIV_LAT-1].neg_y ? -$signed(40'(qy)) : $signed(40'(qy));
    sx    = basex + ox;
    sy    = basey - oy;
  end

  // Output register with saturation; hidden points read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      out_vis  <= 1'b0;
      out_x    <= '0;
      out_y    <= '0;
    end else if (en) begin
      m_tvalid <= tag[ppu_pkg::DIV_LAT-1].valid;
      out_vis  <= tag[ppu_pkg::DIV_LAT-1].vis;
      if (!tag[ppu_pkg::DIV_LAT-1].vis) begin
        out_x <= '0;
        out_y <= '0;
      end else begin
        out_x <= (sx > 40'sh007FFFFFFF) ? 32'h7FFFFFFF :
                 (sx < -40'sh0080000000) ? 32'h80000000 : sx[31:0];
        out_y <= (sy > 40'sh007FFFFFFF) ? 32'h7FFFFFFF :
                 (sy < -40'sh0080000000) ? 32'h80000000 : sy[31:0];
      end
    end
  end

  assign m_tdata = {7'd0, out_y, out_x, out_vis};

  // Checks.
  `PPU_ASSERT_IMP(hidden_is_zero, m_tvalid && !out_vis, (out_x == 32'd0) && (out_y == 32'd0))
  `PPU_ASSERT_NEXT(reset_empties_output, rst, !m_tvalid)
  `PPU_ASSERT_IMP(no_tag_without_request, tag[0].valid && $past(en) && !$past(rst),
                  $past(clip.valid))

endmodule
